/* rtl/core/mep_pkg.sv */
// ============================================================================
// mep_pkg: shared types, constants and functions of the Mandelbrot pixel core
// Fixed-point formats, controller states, command and status groups, and
// the palette function that fills the color tables at elaboration.
// ============================================================================
`default_nettype none

package mep_pkg;

  // Orbit format: signed, 4 integer bits (sign included), FRAC_BITS fraction.
  localparam int FRAC_BITS = 28;
  localparam int QW        = FRAC_BITS + 4;
  // A product shifted down by FRAC_BITS, and the headroom for the sums.
  localparam int MULW      = 2 * QW - FRAC_BITS;
  localparam int SUMW      = MULW + 2;
  // Divider: quotient bits below the cap, and the output width with the cap.
  localparam int QB        = FRAC_BITS + 4;
  localparam int QOW       = QB + 1;

  // Configuration registers.
  localparam int DIMW     = 13;
  localparam int DENW     = DIMW + 1;
  localparam int CFG_IDXW = 4;
  localparam logic [CFG_IDXW-1:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_IDXW-1:0] REG_IMAGE_HEIGHT = 4'd1;
  localparam logic [DIMW-1:0]     DIM_RESET        = 13'd1024;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // Saturation bounds of the orbit format, also sign-extended to SUMW.
  localparam logic signed [QW-1:0]   Q_MAX  = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0]   Q_MIN  = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [SUMW-1:0] SAT_HI = {{(SUMW-QW+1){1'b0}}, {(QW-1){1'b1}}};
  localparam logic signed [SUMW-1:0] SAT_LO = {{(SUMW-QW+1){1'b1}}, {(QW-1){1'b0}}};

  // Horizontal offset 2.1, rounded to nearest.
  localparam logic [63:0] TWO_ONE_W = ((64'd21 << FRAC_BITS) + 64'd5) / 64'd10;
  localparam logic signed [SUMW-1:0] TWO_ONE = TWO_ONE_W[SUMW-1:0];

  // Escape bound 4.0 at the width of the sum of two squares.
  localparam logic [MULW:0] ESC_LIMIT =
    {{(MULW-FRAC_BITS-2){1'b0}}, 3'b100, {FRAC_BITS{1'b0}}};

  // Palette arithmetic constants.
  localparam longint C_ONE      = 64'sd1073741824;
  localparam longint TWO_PI_Q28 = 64'sd1686629713;

  // Palette channels.
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef logic signed [QW-1:0] q_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_WAIT_X,
    ST_DIV_Y,
    ST_WAIT_Y,
    ST_ITER,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic div_sel_y;
    logic load_cx;
    logic load_cy;
    logic iter_step;
    logic iter_latch;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic iter_end;
    logic out_free;
  } dp_status_t;

  // Clamp a wide signed sum into the orbit format.
  function automatic q_t sat_q(input logic signed [SUMW-1:0] v);
    if (v > SAT_HI) return Q_MAX;
    if (v < SAT_LO) return Q_MIN;
    return v[QW-1:0];
  endfunction

  // Long division of a non-negative value by a positive one, by shift and
  // subtract. Gives the quotient, or the remainder when want_rem is set.
  // Used only to build constant tables.
  function automatic longint udivmod(input longint num, input longint den,
                                     input bit want_rem);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r <<< 1) | ((num >>> b) & 64'sd1);
      q = q <<< 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'sd1;
      end
    end
    return want_rem ? r : q;
  endfunction

  // Signed quotient rounded toward zero, for a positive divisor.
  function automatic longint sdiv(input longint num, input longint den);
    longint mag;
    mag = udivmod((num < 0) ? -num : num, den, 1'b0);
    return (num < 0) ? -mag : mag;
  endfunction

  // Palette byte floor(255 * (d + e*cos(2*pi*(f*t + g)))) for t = n/max_iter,
  // with the cosine taken from a folded Q30 Taylor series. Used only to
  // build constant tables.
  function automatic logic [7:0] pal_byte(input int ch, input int n, input int max_iter);
    longint pd;
    longint pe;
    longint pf;
    longint pg;
    longint den;
    longint num;
    longint xq;
    longint th;
    longint th2;
    longint r;
    longint s;
    longint t;
    longint v;
    bit     neg;
    unique case (ch)
      CH_GREEN: begin
        pd = 3; pe = -3; pf = 20; pg = 1;
      end
      CH_BLUE: begin
        pd = 5; pe = -5; pf = 30; pg = 0;
      end
      default: begin
        pd = 3; pe = -2; pf = 21; pg = 0;
      end
    endcase
    neg = 1'b0;
    r   = C_ONE;
    den = 10 * longint'(max_iter);
    num = udivmod(pf * longint'(n) + pg * longint'(max_iter), den, 1'b1);
    xq  = udivmod(num <<< 32, den, 1'b0);
    // Fold the turn angle into the first quadrant.
    if (xq >= (longint'(1) <<< 31)) xq = (longint'(1) <<< 32) - xq;
    if (xq > (longint'(1) <<< 30)) begin
      neg = 1'b1;
      xq  = (longint'(1) <<< 31) - xq;
    end
    th  = (xq * TWO_PI_Q28) >>> 30;
    th2 = sdiv(th * th, C_ONE);
    for (int k = 8; k >= 1; k--) begin
      t = sdiv(th2 * r, C_ONE);
      r = C_ONE - sdiv(t, longint'((2 * k - 1) * (2 * k)));
    end
    if (neg) r = -r;
    s = pd * C_ONE + pe * r;
    if (s < 0) return 8'd0;
    v = sdiv(s * 255, 10 * C_ONE);
    if (v > 255) return 8'hFF;
    return v[7:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/mandelbrot_escape_pixel.sv */
// ============================================================================
// mandelbrot_escape_pixel: escape-time Mandelbrot pixel with cosine palette
// Maps a pixel to c, iterates z = z*z + c and colors the escape count.
// ============================================================================
// Usage:
//   Input channel in_valid/in_stall carries one pixel (column, row). The core
//   takes a transaction only when it is idle; in_stall is high from the cycle
//   after acceptance until the result has entered the output register.
//   Output channel out_valid/out_stall carries RGBA bytes and the iteration
//   count, one result per pixel, held in a register; a new pixel can be taken
//   while that result still waits for the sink.
//   Two sequential divisions, each giving FRAC_BITS+4 quotient bits, set up c,
//   and the orbit loop then runs one iteration per cycle through three
//   parallel multipliers. A division that saturates skips the shift steps
//   and returns the cap directly.
//   Configuration (image width, image height) is written through the cfg
//   port; the user must write it only while the core is idle, as the core
//   does not enforce this. Reset (rst_n low, synchronous) returns both
//   registers to 1024 and empties the core and the output register.
//   If the sink stalls, the finished count waits in the datapath and the
//   controller stays in ST_FIN until the register is free; nothing is dropped.
// ============================================================================
`default_nettype none

module mandelbrot_escape_pixel #(
  parameter int COORD_BITS = 12,
  parameter int MAX_ITER   = 128
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [mep_pkg::CFG_IDXW-1:0]  cfg_index,
  input  wire logic [mep_pkg::DIMW-1:0]      cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [COORD_BITS-1:0]         in_pixel_col,
  input  wire logic [COORD_BITS-1:0]         in_pixel_row,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         out_red,
  output logic [7:0]                         out_green,
  output logic [7:0]                         out_blue,
  output logic [7:0]                         out_alpha,
  output logic [7:0]                         out_iter_count
);

  mep_pkg::ctrl_cmd_t  cmd;
  mep_pkg::dp_status_t status;

  mep_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mep_datapath #(
    .COORD_BITS (COORD_BITS),
    .MAX_ITER   (MAX_ITER)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_pixel_col   (in_pixel_col),
    .in_pixel_row   (in_pixel_row),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .out_iter_count (out_iter_count)
  );

  // An accepted pixel keeps the input side closed in the following cycle.
  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while the previous pixel was not yet started");

  // A result is only loaded into a free output register.
  a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over an untaken output transaction");

  // Coordinates are only taken from a finished division.
  a_coord_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_cx || cmd.load_cy) |-> status.div_done)
    else $error("coordinate loaded before the divider finished");

  // The orbit only advances while no new pixel can be accepted.
  a_iter_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.iter_step |-> in_stall)
    else $error("orbit step while the input side is open");

endmodule

`default_nettype wire

/* rtl/core/mep_div.sv */
// ============================================================================
// mep_div: sequential fixed-point divider
// Restoring division giving floor(num * 2^FRAC_BITS / den), one quotient bit
// per cycle, with the result capped at 16.0 when the integer part reaches 16.
// ============================================================================
`default_nettype none

module mep_div #(
  parameter int NUM_BITS = 15
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [NUM_BITS-1:0]         num,
  input  wire logic [mep_pkg::DENW-1:0]    den,
  output logic                             done,
  output logic [mep_pkg::QOW-1:0]          quot
);

  localparam int DSHW = mep_pkg::DENW + 4;
  localparam int CW   = (NUM_BITS > DSHW) ? NUM_BITS : DSHW;
  localparam int RW   = DSHW + 1;
  localparam int CNTW = $clog2(mep_pkg::QB + 1);
  localparam logic [mep_pkg::QOW-1:0] CAP = {1'b1, {mep_pkg::QB{1'b0}}};

  logic [CW-1:0]            num_ext;
  logic [CW-1:0]            dsh_ext;
  logic                     cap;
  logic [RW-1:0]            rem_r;
  logic [RW-1:0]            dsh_r;
  logic [RW-1:0]            rem_sh;
  logic                     take;
  logic [mep_pkg::QOW-1:0]  quot_r;
  logic [CNTW-1:0]          cnt_r;
  logic                     busy_r;
  logic                     done_r;

  // The divisor is scaled by 16 so that an uncapped remainder stays below it.
  assign num_ext = CW'(num);
  assign dsh_ext = CW'({den, 4'b0000});
  assign cap     = (num_ext >= dsh_ext);

  assign rem_sh = {rem_r[RW-2:0], 1'b0};
  assign take   = (rem_sh >= dsh_r);

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNTW'(mep_pkg::QB);
        if (cap) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      dsh_r  <= RW'({den, 4'b0000});
      rem_r  <= {1'b0, num_ext[RW-2:0]};
      quot_r <= cap ? CAP : '0;
    end else if (busy_r) begin
      rem_r  <= take ? (rem_sh - dsh_r) : rem_sh;
      quot_r <= {quot_r[mep_pkg::QOW-2:0], take};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

/* rtl/core/mep_datapath.sv */
// ============================================================================
// mep_datapath: configuration, coordinate setup, orbit and palette datapath
// Holds the image registers, maps the pixel to c through the divider, runs
// one orbit iteration per cycle and drives the registered result.
// ============================================================================
`default_nettype none

module mep_datapath #(
  parameter int COORD_BITS = 12,
  parameter int MAX_ITER   = 128
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [mep_pkg::CFG_IDXW-1:0]    cfg_index,
  input  wire logic [mep_pkg::DIMW-1:0]        cfg_wdata,
  input  wire logic [COORD_BITS-1:0]           in_pixel_col,
  input  wire logic [COORD_BITS-1:0]           in_pixel_row,
  input  wire mep_pkg::ctrl_cmd_t              cmd,
  output mep_pkg::dp_status_t                  status,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [7:0]                           out_red,
  output logic [7:0]                           out_green,
  output logic [7:0]                           out_blue,
  output logic [7:0]                           out_alpha,
  output logic [7:0]                           out_iter_count
);

  localparam int VW   = (COORD_BITS + 1 > mep_pkg::DIMW) ? COORD_BITS + 1 : mep_pkg::DIMW;
  localparam int VDW  = VW + 1;
  localparam int NUMW = VW + 2;
  localparam int NW   = $clog2(MAX_ITER + 1);
  localparam int QW   = mep_pkg::QW;
  localparam int SUMW = mep_pkg::SUMW;
  localparam int MULW = mep_pkg::MULW;
  localparam int FB   = mep_pkg::FRAC_BITS;

  logic [mep_pkg::DIMW-1:0] width_r;
  logic [mep_pkg::DIMW-1:0] height_r;
  logic [COORD_BITS-1:0]    col_r;
  logic [COORD_BITS-1:0]    row_r;

  logic [mep_pkg::DIMW-1:0] w_eff;
  logic [NUMW-1:0]          num_x;
  logic [VDW-1:0]           two_row;
  logic [VDW-1:0]           h_ext;
  logic signed [VDW-1:0]    vdiff;
  logic signed [VDW+1:0]    vd_ext;
  logic signed [VDW+1:0]    vnum3;
  logic [VDW+1:0]           vabs_full;
  logic                     vneg;

  logic [NUMW-1:0]          div_num;
  logic [mep_pkg::DENW-1:0] div_den;
  logic                     div_done;
  logic [mep_pkg::QOW-1:0]  div_quot;
  logic signed [SUMW-1:0]   quot_ext;
  logic signed [SUMW-1:0]   cx_sum;
  logic signed [SUMW-1:0]   cy_sum;

  mep_pkg::q_t              cx_r;
  mep_pkg::q_t              cy_r;
  mep_pkg::q_t              zx_r;
  mep_pkg::q_t              zy_r;
  logic [NW-1:0]            cnt_r;
  logic [NW-1:0]            nfin_r;

  logic signed [2*QW-1:0]   pxx;
  logic signed [2*QW-1:0]   pyy;
  logic signed [2*QW-1:0]   pxy;
  logic signed [MULW-1:0]   sx;
  logic signed [MULW-1:0]   sy;
  logic signed [MULW-1:0]   sxy;
  logic signed [SUMW-1:0]   nx_sum;
  logic signed [SUMW-1:0]   ny_sum;
  logic [MULW:0]            mag2;
  logic                     escape;
  logic                     at_limit;

  logic [7:0]               pal_r_tab [MAX_ITER+1];
  logic [7:0]               pal_g_tab [MAX_ITER+1];
  logic [7:0]               pal_b_tab [MAX_ITER+1];
  logic [NW+7:0]            n_ext;

  logic                     out_valid_r;
  logic [7:0]               red_r;
  logic [7:0]               green_r;
  logic [7:0]               blue_r;
  logic [7:0]               count_r;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= mep_pkg::DIM_RESET;
      height_r <= mep_pkg::DIM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mep_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        mep_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pixel capture on an accepted input transaction.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col_r <= in_pixel_col;
      row_r <= in_pixel_row;
    end
  end

  // Divider operands: 3*col / width, and |3*(2*row - height)| / (2*width).
  assign w_eff     = (width_r == '0) ? mep_pkg::DIMW'(1) : width_r;
  assign num_x     = NUMW'({col_r, 1'b0}) + NUMW'(col_r);
  assign two_row   = VDW'({row_r, 1'b0});
  assign h_ext     = VDW'(height_r);
  assign vdiff     = $signed(two_row) - $signed(h_ext);
  assign vd_ext    = {{2{vdiff[VDW-1]}}, vdiff};
  assign vnum3     = vd_ext + $signed({vd_ext[VDW:0], 1'b0});
  assign vneg      = vnum3[VDW+1];
  assign vabs_full = vneg ? $unsigned(-vnum3) : $unsigned(vnum3);

  assign div_num = cmd.div_sel_y ? vabs_full[NUMW-1:0] : num_x;
  assign div_den = cmd.div_sel_y ? {w_eff, 1'b0} : {1'b0, w_eff};

  mep_div #(
    .NUM_BITS (NUMW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Point c from the quotients, saturated into the orbit format.
  assign quot_ext = $signed(SUMW'(div_quot));
  assign cx_sum   = quot_ext - mep_pkg::TWO_ONE;
  assign cy_sum   = vneg ? -quot_ext : quot_ext;

  always_ff @(posedge clk) begin
    if (cmd.load_cx) begin
      cx_r <= mep_pkg::sat_q(cx_sum);
    end
    if (cmd.load_cy) begin
      cy_r <= mep_pkg::sat_q(cy_sum);
    end
  end

  // Squares and cross product of the current orbit point, floored.
  assign pxx = zx_r * zx_r;
  assign pyy = zy_r * zy_r;
  assign pxy = zx_r * zy_r;
  assign sx  = pxx[2*QW-1:FB];
  assign sy  = pyy[2*QW-1:FB];
  assign sxy = pxy[2*QW-1:FB];

  // Next point, and the escape test of the current one (its squares are
  // the same ones that feed the next point).
  assign nx_sum   = {{2{sx[MULW-1]}}, sx} - {{2{sy[MULW-1]}}, sy}
                  + {{(SUMW-QW){cx_r[QW-1]}}, cx_r};
  assign ny_sum   = {sxy[MULW-1], sxy, 1'b0} + {{(SUMW-QW){cy_r[QW-1]}}, cy_r};
  assign mag2     = {1'b0, sx} + {1'b0, sy};
  assign escape   = (mag2 > mep_pkg::ESC_LIMIT);
  assign at_limit = (cnt_r == NW'(MAX_ITER));

  // Orbit registers: cleared at setup, advanced once per cycle while the orbit step command is set.
  always_ff @(posedge clk) begin
    if (cmd.load_cy) begin
      zx_r  <= '0;
      zy_r  <= '0;
      cnt_r <= '0;
    end else if (cmd.iter_step) begin
      zx_r  <= mep_pkg::sat_q(nx_sum);
      zy_r  <= mep_pkg::sat_q(ny_sum);
      cnt_r <= cnt_r + NW'(1);
    end
    if (cmd.iter_latch) begin
      nfin_r <= escape ? (cnt_r - NW'(1)) : cnt_r;
    end
  end

  // Palette tables, one byte per iteration count and channel.
  for (genvar gi = 0; gi <= MAX_ITER; gi++) begin : g_pal
    localparam logic [7:0] PR = mep_pkg::pal_byte(mep_pkg::CH_RED, gi, MAX_ITER);
    localparam logic [7:0] PG = mep_pkg::pal_byte(mep_pkg::CH_GREEN, gi, MAX_ITER);
    localparam logic [7:0] PB = mep_pkg::pal_byte(mep_pkg::CH_BLUE, gi, MAX_ITER);
    assign pal_r_tab[gi] = PR;
    assign pal_g_tab[gi] = PG;
    assign pal_b_tab[gi] = PB;
  end

  assign n_ext = {8'b0, nfin_r};

  // Output register: loaded from the tables, emptied when the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      red_r   <= pal_r_tab[nfin_r];
      green_r <= pal_g_tab[nfin_r];
      blue_r  <= pal_b_tab[nfin_r];
      count_r <= n_ext[7:0];
    end
  end

  assign status.div_done = div_done;
  assign status.iter_end = escape || at_limit;
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;
  assign out_alpha      = mep_pkg::ALPHA_OPAQUE;
  assign out_iter_count = count_r;

endmodule

`default_nettype wire

/* rtl/core/mep_ctrl.sv */
// ============================================================================
// mep_ctrl: sequencing state machine of the Mandelbrot pixel core
// Steps one pixel through capture, two divisions, the orbit loop and the
// hand-off to the output register.
// ============================================================================
`default_nettype none

module mep_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire mep_pkg::dp_status_t  status,
  output mep_pkg::ctrl_cmd_t        cmd
);

  mep_pkg::state_t state_r;
  mep_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mep_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mep_pkg::ST_IDLE:   if (in_valid) state_nxt = mep_pkg::ST_DIV_X;
      mep_pkg::ST_DIV_X:  state_nxt = mep_pkg::ST_WAIT_X;
      mep_pkg::ST_WAIT_X: if (status.div_done) state_nxt = mep_pkg::ST_DIV_Y;
      mep_pkg::ST_DIV_Y:  state_nxt = mep_pkg::ST_WAIT_Y;
      mep_pkg::ST_WAIT_Y: if (status.div_done) state_nxt = mep_pkg::ST_ITER;
      mep_pkg::ST_ITER:   if (status.iter_end) state_nxt = mep_pkg::ST_FIN;
      mep_pkg::ST_FIN:    if (status.out_free) state_nxt = mep_pkg::ST_IDLE;
      default:            state_nxt = mep_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      mep_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      mep_pkg::ST_DIV_X: begin
        cmd.div_start = 1'b1;
      end
      mep_pkg::ST_WAIT_X: begin
        cmd.load_cx = status.div_done;
      end
      mep_pkg::ST_DIV_Y: begin
        cmd.div_start = 1'b1;
        cmd.div_sel_y = 1'b1;
      end
      mep_pkg::ST_WAIT_Y: begin
        cmd.div_sel_y = 1'b1;
        cmd.load_cy   = status.div_done;
      end
      mep_pkg::ST_ITER: begin
        cmd.iter_step  = !status.iter_end;
        cmd.iter_latch = status.iter_end;
      end
      mep_pkg::ST_FIN: begin
        cmd.out_load = status.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* test/tb_mandelbrot_escape_pixel.sv */
// ============================================================================
// tb_mandelbrot_escape_pixel: self-checking regression of the pixel core
// Drives pixel coordinates under a range of image sizes. Each pixel is scored
// against an in-bench fixed-point model of the escape-time loop and the cosine
// palette. The source sends in random bursts and the sink stalls at random,
// with one long sink hold-off that backs the core up onto its input.
// ============================================================================
module tb_mandelbrot_escape_pixel;

  // Fixed-point model constants (Q4.28 orbit, Q30 cosine).
  localparam int     ORBIT_FRAC  = 28;
  localparam int     ITER_LIMIT  = 128;
  localparam longint ORBIT_MAX   = (64'sd8 <<< ORBIT_FRAC) - 64'sd1;
  localparam longint ORBIT_MIN   = -(64'sd8 <<< ORBIT_FRAC);
  localparam longint DIV_CAP     = 64'sd16 <<< ORBIT_FRAC;
  localparam longint ESCAPE_R2   = 64'sd4 <<< ORBIT_FRAC;
  localparam longint OFFSET_2P1  = ((64'sd21 <<< ORBIT_FRAC) + 64'sd5) / 64'sd10;
  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint TURN_TO_RAD = 64'sd1686629713;

  // Register indexes with no register behind them.
  localparam logic [mep_pkg::CFG_IDXW-1:0] REG_FIRST_SPARE = 4'd2;
  localparam logic [mep_pkg::CFG_IDXW-1:0] REG_LAST_SPARE  = 4'hF;

  localparam int PHASES        = 9;
  localparam int PHASE_PIXELS  = 100;
  localparam int HOLD_AFTER    = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 250;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [mep_pkg::DIMW-1:0] width;
    logic [mep_pkg::DIMW-1:0] height;
    logic [11:0]              col;
    logic [11:0]              row;
    logic                     known;
    logic [7:0]               iters;
  } probe_t;

  typedef struct {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  iters;
    logic [11:0] col;
    logic [11:0] row;
  } pixel_color_t;

  // Directed pixels. The iteration count is typed in where the point is
  // plainly far outside the set (zero) or deep in the main cardioid (128).
  localparam int N_PROBES = 22;
  localparam probe_t PROBES [N_PROBES] = '{
    '{13'd1024, 13'd1024, 12'd512,  12'd512,  1'b1, 8'd128},
    '{13'd1024, 13'd1024, 12'd0,    12'd0,    1'b1, 8'd0},
    '{13'd1024, 13'd1024, 12'd4095, 12'd4095, 1'b1, 8'd0},
    '{13'd1024, 13'd1024, 12'd0,    12'd512,  1'b1, 8'd0},
    '{13'd1024, 13'd1024, 12'd4095, 12'd0,    1'b1, 8'd0},
    '{13'd1024, 13'd1024, 12'd700,  12'd512,  1'b0, 8'd0},
    '{13'd1024, 13'd1024, 12'd300,  12'd690,  1'b0, 8'd0},
    '{13'd1024, 13'd1024, 12'd2730, 12'd1365, 1'b0, 8'd0},
    '{13'd0,    13'd1024, 12'd0,    12'd0,    1'b1, 8'd0},
    '{13'd0,    13'd1024, 12'd4095, 12'd4095, 1'b1, 8'd0},
    '{13'd1,    13'd1,    12'd0,    12'd0,    1'b1, 8'd0},
    '{13'd1,    13'd1,    12'd1,    12'd0,    1'b0, 8'd0},
    '{13'd4096, 13'd4096, 12'd2800, 12'd2048, 1'b1, 8'd128},
    '{13'd4096, 13'd4096, 12'd4095, 12'd4095, 1'b0, 8'd0},
    '{13'd8191, 13'd8191, 12'd0,    12'd4095, 1'b1, 8'd0},
    '{13'd8191, 13'd8191, 12'd4095, 12'd4095, 1'b0, 8'd0},
    '{13'd8191, 13'd1,    12'd4095, 12'd0,    1'b1, 8'd128},
    '{13'd640,  13'd480,  12'd320,  12'd240,  1'b1, 8'd128},
    '{13'd640,  13'd480,  12'd100,  12'd400,  1'b0, 8'd0},
    '{13'd3,    13'd7,    12'd2,    12'd1,    1'b1, 8'd0},
    '{13'd1024, 13'd0,    12'd512,  12'd0,    1'b1, 8'd128},
    '{13'd1024, 13'd2048, 12'd300,  12'd1500, 1'b0, 8'd0}
  };

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         cfg_wr_en;
  logic [mep_pkg::CFG_IDXW-1:0] cfg_index;
  logic [mep_pkg::DIMW-1:0]     cfg_wdata;
  logic                         in_valid;
  logic                         in_stall;
  logic [11:0]                  in_pixel_col;
  logic [11:0]                  in_pixel_row;
  logic                         out_valid;
  logic                         out_stall;
  logic [7:0]                   out_red;
  logic [7:0]                   out_green;
  logic [7:0]                   out_blue;
  logic [7:0]                   out_alpha;
  logic [7:0]                   out_iter_count;

  // Typed expectation that travels with the pixel being offered.
  logic                         typed_on;
  logic [7:0]                   typed_iter;

  // Image size as the core holds it, tracked from the configuration writes.
  logic [mep_pkg::DIMW-1:0]     img_w;
  logic [mep_pkg::DIMW-1:0]     img_h;
  // Image size last programmed by the stimulus.
  logic [mep_pkg::DIMW-1:0]     cur_w;
  logic [mep_pkg::DIMW-1:0]     cur_h;

  pixel_color_t        colors_due[$];
  int                  pixels_taken   = 0;
  int                  results_seen   = 0;
  int                  mismatch_count = 0;
  int                  escaped_first  = 0;
  int                  escaped_later  = 0;
  int                  never_escaped  = 0;
  int                  settings_used  = 0;

  mandelbrot_escape_pixel dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_col   (in_pixel_col),
    .in_pixel_row   (in_pixel_row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .out_iter_count (out_iter_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clamp to the orbit range [-8, 8).
  function automatic longint clamp_orbit(input longint v);
    if (v > ORBIT_MAX) return ORBIT_MAX;
    if (v < ORBIT_MIN) return ORBIT_MIN;
    return v;
  endfunction

  // Fixed-point product, rounded toward minus infinity.
  function automatic longint fix_mul(input longint a, input longint b);
    longint p;
    p = a * b;
    return p >>> ORBIT_FRAC;
  endfunction

  // Truncated quotient with ORBIT_FRAC fraction bits, capped at 16.
  function automatic longint fix_div(input longint num, input longint den);
    if (num / den >= 64'sd16) return DIV_CAP;
    return (num <<< ORBIT_FRAC) / den;
  endfunction

  // Number of orbit steps that stay within radius 2 for one pixel.
  function automatic int escape_steps(input longint col, input longint row,
                                      input longint w, input longint h);
    longint wd;
    longint cx;
    longint cy;
    longint zx;
    longint zy;
    longint nx;
    longint ny;
    longint vnum;
    longint mag;
    int     n;
    bit     out;
    wd   = (w == 0) ? 64'sd1 : w;
    cx   = clamp_orbit(fix_div(3 * col, wd) - OFFSET_2P1);
    vnum = 3 * (2 * row - h);
    mag  = fix_div((vnum < 0) ? -vnum : vnum, 2 * wd);
    cy   = clamp_orbit((vnum < 0) ? -mag : mag);
    zx   = 0;
    zy   = 0;
    n    = 0;
    out  = 1'b0;
    while (n < ITER_LIMIT && !out) begin
      nx = clamp_orbit(fix_mul(zx, zx) - fix_mul(zy, zy) + cx);
      ny = clamp_orbit(2 * fix_mul(zx, zy) + cy);
      if (fix_mul(nx, nx) + fix_mul(ny, ny) > ESCAPE_R2) begin
        out = 1'b1;
      end else begin
        n++;
        zx = nx;
        zy = ny;
      end
    end
    return n;
  endfunction

  // cos(2*pi*x) in Q30 for x in Q32 turns, by a folded Taylor series.
  function automatic longint cosine_q30(input longint turns);
    longint x;
    longint ang;
    longint ang2;
    longint acc;
    bit     flip;
    x    = turns;
    flip = 1'b0;
    if (x >= (64'sd1 <<< 31)) x = (64'sd1 <<< 32) - x;
    if (x > (64'sd1 <<< 30)) begin
      flip = 1'b1;
      x    = (64'sd1 <<< 31) - x;
    end
    ang  = (x * TURN_TO_RAD) >>> 30;
    ang2 = (ang * ang) / Q30_ONE;
    acc  = Q30_ONE;
    for (int k = 8; k >= 1; k--) begin
      acc = Q30_ONE - ((ang2 * acc) / Q30_ONE) / longint'((2 * k - 1) * (2 * k));
    end
    return flip ? -acc : acc;
  endfunction

  // One palette channel for an escape count.
  function automatic logic [7:0] palette_byte(input int ch, input int n);
    longint base;
    longint amp;
    longint freq;
    longint phase;
    longint turns;
    longint level;
    longint v;
    case (ch)
      mep_pkg::CH_RED: begin
        base = 3; amp = -2; freq = 21; phase = 0;
      end
      mep_pkg::CH_GREEN: begin
        base = 3; amp = -3; freq = 20; phase = 1;
      end
      default: begin
        base = 5; amp = -5; freq = 30; phase = 0;
      end
    endcase
    turns = (freq * n + phase * ITER_LIMIT) % (10 * ITER_LIMIT);
    level = base * Q30_ONE + amp * cosine_q30((turns <<< 32) / (10 * ITER_LIMIT));
    if (level < 0) return 8'd0;
    v = (level * 255) / (10 * Q30_ONE);
    return (v > 255) ? 8'hFF : v[7:0];
  endfunction

  // A coordinate mostly inside the image, now and then anywhere.
  function automatic logic [11:0] pick_coord(input int lim);
    if (lim > 4096) lim = 4096;
    if (lim < 1) lim = 1;
    if ($urandom_range(0, 4) == 0) return 12'($urandom_range(0, 4095));
    return 12'($urandom_range(0, lim - 1));
  endfunction

  function automatic logic [mep_pkg::DIMW-1:0] edge_dim();
    case ($urandom_range(0, 3))
      0:       return 13'd0;
      1:       return 13'd1;
      2:       return 13'd4096;
      default: return 13'd8191;
    endcase
  endfunction

  // Offer one pixel and hold it until the core takes it.
  task automatic send_pixel(input logic [11:0] col, input logic [11:0] row,
                            input logic known, input logic [7:0] iters);
    in_valid     <= 1'b1;
    in_pixel_col <= col;
    in_pixel_row <= row;
    typed_on     <= known;
    typed_iter   <= iters;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering and wait until every pending color has come out.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (colors_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Program the image size, plus one write to an index with no register.
  task automatic program_image(input logic [mep_pkg::DIMW-1:0] w,
                               input logic [mep_pkg::DIMW-1:0] h);
    cfg_wr_en <= 1'b1;
    cfg_index <= mep_pkg::REG_IMAGE_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= mep_pkg::REG_IMAGE_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_index <= mep_pkg::CFG_IDXW'($urandom_range(REG_FIRST_SPARE, REG_LAST_SPARE));
    cfg_wdata <= mep_pkg::DIMW'($urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_w = w;
    cur_h = h;
    settings_used++;
  endtask

  // Source: directed table first, then random phases, sent in bursts.
  initial begin : source
    int burst_left;
    int gap;
    rst_n        <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_index    <= mep_pkg::REG_IMAGE_WIDTH;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    in_pixel_col <= '0;
    in_pixel_row <= '0;
    typed_on     <= 1'b0;
    typed_iter   <= '0;
    cur_w = mep_pkg::DIM_RESET;
    cur_h = mep_pkg::DIM_RESET;
    burst_left = $urandom_range(1, 40);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_PROBES + PHASES * PHASE_PIXELS; i++) begin
      if (i < N_PROBES) begin
        if (PROBES[i].width != cur_w || PROBES[i].height != cur_h) begin
          settle();
          program_image(PROBES[i].width, PROBES[i].height);
        end
        send_pixel(PROBES[i].col, PROBES[i].row, PROBES[i].known, PROBES[i].iters);
      end else begin
        if ((i - N_PROBES) % PHASE_PIXELS == 0) begin
          settle();
          if (i == N_PROBES) program_image(13'd8191, 13'd0);
          else if ($urandom_range(0, 3) == 0) program_image(edge_dim(), edge_dim());
          else program_image(mep_pkg::DIMW'($urandom_range(8, 4096)),
                             mep_pkg::DIMW'($urandom_range(8, 4096)));
        end
        send_pixel(pick_coord(cur_w), pick_coord(cur_h), 1'b0, 8'd0);
      end
      // End of a burst: idle for a short or a long gap.
      burst_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 250) : $urandom_range(1, 20);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 40);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d pixels under %0d image sizes; escape counts: %0d at once,",
             pixels_taken, settings_used, escaped_first);
    $display("  %0d after some steps, %0d never; %0d colors checked, %0d mismatches.",
             escaped_later, never_escaped, results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("mandelbrot_escape_pixel regression: pass");
    end else begin
      $display("mandelbrot_escape_pixel regression: fail");
    end
    $finish;
  end

  // Sink: stall on a pattern of its own, with one long hold-off.
  initial begin : sink
    int  mode;
    int  span;
    bit  held;
    held = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held && pixels_taken >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 1) == 1);
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Track configuration, predict each accepted pixel and score each result.
  always @(posedge clk) begin : scoreboard
    pixel_color_t want;
    pixel_color_t got;
    int           n;
    if (!rst_n) begin
      img_w = mep_pkg::DIM_RESET;
      img_h = mep_pkg::DIM_RESET;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          mep_pkg::REG_IMAGE_WIDTH:  img_w = cfg_wdata;
          mep_pkg::REG_IMAGE_HEIGHT: img_h = cfg_wdata;
          default: ;
        endcase
      end

      // Input transaction: work out the color it must produce.
      if (in_valid && !in_stall) begin
        n = escape_steps(longint'(in_pixel_col), longint'(in_pixel_row),
                         longint'(img_w), longint'(img_h));
        want.red   = palette_byte(mep_pkg::CH_RED, n);
        want.green = palette_byte(mep_pkg::CH_GREEN, n);
        want.blue  = palette_byte(mep_pkg::CH_BLUE, n);
        want.alpha = mep_pkg::ALPHA_OPAQUE;
        want.iters = typed_on ? typed_iter : n[7:0];
        want.col   = in_pixel_col;
        want.row   = in_pixel_row;
        colors_due.push_back(want);
        pixels_taken++;
        if (n == 0) escaped_first++;
        else if (n == ITER_LIMIT) never_escaped++;
        else escaped_later++;
      end

      // Output transaction: compare with the oldest pending color.
      if (out_valid && !out_stall) begin
        results_seen++;
        got.red   = out_red;
        got.green = out_green;
        got.blue  = out_blue;
        got.alpha = out_alpha;
        got.iters = out_iter_count;
        if (colors_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("ERROR: unexpected result rgba %0d %0d %0d %0d n=%0d",
                     got.red, got.green, got.blue, got.alpha, got.iters);
        end else begin
          want = colors_due.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.alpha !== want.alpha ||
              got.iters !== want.iters) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("ERROR: pixel (%0d,%0d) expected rgba %0d %0d %0d %0d n=%0d,",
                       want.col, want.row, want.red, want.green, want.blue,
                       want.alpha, want.iters);
              $display("       got rgba %0d %0d %0d %0d n=%0d",
                       got.red, got.green, got.blue, got.alpha, got.iters);
            end
          end
        end
      end
    end
  end

  // Watchdog, several times the slowest legal run.
  initial begin : watchdog
    #20000000;
    $display("Timeout with %0d colors still pending.", colors_due.size());
    $display("mandelbrot_escape_pixel regression: fail");
    $finish;
  end

endmodule
